// File: rtl/rc5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5 package
// Shared word and pipeline types, the fixed round-key table and rotate helpers.
// ----------------------------------------------------------------------------
package rc5_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned MAX_ROUNDS = 12;
   localparam int unsigned KEY_WORDS  = 2 * MAX_ROUNDS + 2;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [SHIFT_W-1:0] shamt_type;

   // Operation select carried with each block
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // One pipeline slot: valid flag, operation and the two working words
   typedef struct packed {
      logic     vld;
      logic     op;
      word_type a;
      word_type b;
   } pipe_type;

   // Fixed expanded key table S[0..25]
   localparam word_type KEY_TABLE [KEY_WORDS] = '{
      32'd2612779208, 32'd439875579,  32'd1190717637, 32'd1175216261,
      32'd1895316362, 32'd676037379,  32'd1363022932, 32'd4129418530,
      32'd824510045,  32'd296237661,  32'd3559352427, 32'd1899681837,
      32'd1266233241, 32'd664380637,  32'd2811239497, 32'd3739125530,
      32'd918565270,  32'd2817507913, 32'd1638370232, 32'd990518571,
      32'd1304414838, 32'd2920685927, 32'd819424010,  32'd1125720836,
      32'd4140569649, 32'd1694786432
   };

   // Rotate left by the low five bits of the amount
   function automatic word_type rotl(input word_type v, input shamt_type n);
      logic [2*WORD_W-1:0] t;
      t = {v, v} << n;
      return t[2*WORD_W-1:WORD_W];
   endfunction

   // Rotate right by the low five bits of the amount
   function automatic word_type rotr(input word_type v, input shamt_type n);
      logic [2*WORD_W-1:0] t;
      t = {v, v} >> n;
      return t[WORD_W-1:0];
   endfunction

endpackage

// File: rtl/rc5_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5 half-round cell
// One registered half-round: even cells update A on encrypt and B on decrypt,
// odd cells the other word. Each cell takes a new block every cycle.
// ----------------------------------------------------------------------------
module rc5_round_cell
   import rc5_pkg::*;
#(
   parameter int unsigned ENC_KEY = 2,
   parameter int unsigned DEC_KEY = 25,
   parameter bit          ODD     = 1'b0
) (
   input  logic     clock,
   input  logic     reset,
   input  pipe_type pipe_i,
   output pipe_type pipe_o
);

   localparam word_type K_ENC = KEY_TABLE[ENC_KEY];
   localparam word_type K_DEC = KEY_TABLE[DEC_KEY];

   pipe_type stage_ff;
   pipe_type stage_in;

   // Compute the half-round for the selected direction
   always_comb begin
      stage_in = pipe_i;
      if (pipe_i.op == OP_ENCRYPT) begin
         if (!ODD) begin
            stage_in.a = rotl(pipe_i.a ^ pipe_i.b, pipe_i.b[SHIFT_W-1:0]) + K_ENC;
         end else begin
            stage_in.b = rotl(pipe_i.b ^ pipe_i.a, pipe_i.a[SHIFT_W-1:0]) + K_ENC;
         end
      end else begin
         if (!ODD) begin
            stage_in.b = rotr(pipe_i.b - K_DEC, pipe_i.a[SHIFT_W-1:0]) ^ pipe_i.a;
         end else begin
            stage_in.a = rotr(pipe_i.a - K_DEC, pipe_i.b[SHIFT_W-1:0]) ^ pipe_i.b;
         end
      end
   end

   // Advance the slot; clear the valid flag on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff.vld <= stage_in.vld;
      end
      stage_ff.op <= stage_in.op;
      stage_ff.a  <= stage_in.a;
      stage_ff.b  <= stage_in.b;
   end

   assign pipe_o = stage_ff;

endmodule

// File: rtl/rc5_block_cipher.sv
`timescale 1ns / 1ps
// An accepted block passes the input register, the cells and the output register to rsp_valid.
// Throughput: one block per cycle; the chain of 2*ROUNDS half-round cells
// plus an input and an output register each hold one block in flight.
// busy stays low: the receiver cannot stall, so nothing ever holds the chain.
// Reset clears every valid flag in the chain; payload registers are not reset.
// ----------------------------------------------------------------------------
// RC5-32 block cipher
// Pipelined RC5-32 encrypt/decrypt with a fixed key table: input whitening on
// encrypt, a row of half-round cells, and output unwhitening for decryption.
// ----------------------------------------------------------------------------
module rc5_block_cipher
   import rc5_pkg::*;
#(
   parameter int unsigned ROUNDS = 12
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  logic     req_type,
   input  word_type req_word_a,
   input  word_type req_word_b,
   output logic     rsp_valid,
   output word_type rsp_out_a,
   output word_type rsp_out_b
);

   localparam int unsigned CELLS = 2 * ROUNDS;

   pipe_type head_ff;
   pipe_type head_in;
   pipe_type chain [CELLS+1];
   pipe_type tail_in;
   logic     rsp_valid_ff;
   word_type rsp_out_a_ff;
   word_type rsp_out_b_ff;

   // The chain never stalls
   assign busy = 1'b0;

   // Whiten on encrypt, pass through on decrypt
   always_comb begin
      head_in.vld = start & ~busy;
      head_in.op  = req_type;
      if (req_type == OP_ENCRYPT) begin
         head_in.a = req_word_a + KEY_TABLE[0];
         head_in.b = req_word_b + KEY_TABLE[1];
      end else begin
         head_in.a = req_word_a;
         head_in.b = req_word_b;
      end
   end

   // Hold the input transfer; clear the valid flag on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.vld <= 1'b0;
      end else begin
         head_ff.vld <= head_in.vld;
      end
      head_ff.op <= head_in.op;
      head_ff.a  <= head_in.a;
      head_ff.b  <= head_in.b;
   end

   assign chain[0] = head_ff;

   // Row of half-round cells
   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      rc5_round_cell #(
         .ENC_KEY (j + 2),
         .DEC_KEY (CELLS + 1 - j),
         .ODD     ((j % 2) == 1)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .pipe_i (chain[j]),
         .pipe_o (chain[j+1])
      );
   end

   // Unwhiten on decrypt, pass through on encrypt
   always_comb begin
      tail_in = chain[CELLS];
      if (chain[CELLS].op == OP_DECRYPT) begin
         tail_in.a = chain[CELLS].a - KEY_TABLE[0];
         tail_in.b = chain[CELLS].b - KEY_TABLE[1];
      end
   end

   // Hold the result for its one strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tail_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_a_ff <= tail_in.a;
      rsp_out_b_ff <= tail_in.b;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_a = rsp_out_a_ff;
   assign rsp_out_b = rsp_out_b_ff;

endmodule

// File: rtl/rc5_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5 port checker
// Watches the top-level ports: fixed latency, no spurious results, no stall.
// ----------------------------------------------------------------------------
module rc5_checker
#(
   parameter int unsigned ROUNDS = 12
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   localparam int unsigned LAT   = 2 * ROUNDS + 2;
   localparam int unsigned CNT_W = $clog2(LAT + 1);

   logic [CNT_W-1:0] warm_ff;
   logic [CNT_W-1:0] warm_in;

   // Count cycles since reset, saturate at the latency
   always_comb begin
      warm_in = warm_ff;
      if (warm_ff != CNT_W'(LAT)) begin
         warm_in = warm_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else begin
         warm_ff <= warm_in;
      end
   end

   // Never refuse a transfer
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   // A result only follows a start by the pipeline latency
   a_rsp_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without matching start");

   // Once warm, every start yields exactly one result at the latency
   a_rsp_matches: assert property (@(posedge clock) disable iff (reset)
      (warm_ff == CNT_W'(LAT)) |-> (rsp_valid == $past(start, LAT)))
      else $error("result strobe does not match start");

   // Reset clears the result strobe
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind rc5_block_cipher rc5_checker #(.ROUNDS(ROUNDS)) u_rc5_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
